FILE: hw/rtl/mf3_pkg.sv
// shared types, constants and codes for the 3x3 replicate median filter
package mf3_pkg;

  localparam int MAX_LINE = 512;
  localparam int LINE_AW  = (MAX_LINE > 1) ? $clog2(MAX_LINE) : 1;
  localparam int LW_W     = 10;
  localparam int PIX_W    = 8;
  localparam int QDEPTH   = 4;
  localparam int QAW      = $clog2(QDEPTH);

  localparam logic [LW_W-1:0] RESET_LW = LW_W'(512);

  typedef logic [PIX_W-1:0] pix_t;

  typedef enum logic {
    CMD_PIXEL = 1'b0,
    CMD_FLUSH = 1'b1
  } mf3_cmd_e;

  // one window column, top to bottom
  typedef struct packed {
    pix_t up;
    pix_t mid;
    pix_t low;
  } mf3_col_t;

  // work item handed from the front to the back
  typedef struct packed {
    logic     flush;
    logic     edge_lo;
    logic     col0;
    logic     emit_a;
    logic     emit_b;
    logic     row_end;
    mf3_col_t col_a;
    mf3_col_t col_b;
  } mf3_entry_t;

endpackage

FILE: hw/rtl/mf3_front.sv
// front end: position tracking, banked row stores and work item build
module mf3_front import mf3_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [LW_W-1:0]  cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             cmd_i,
  input  pix_t             pixel_i,
  input  logic             frame_start_i,
  output mf3_entry_t       q_entry_o,
  output logic             q_push_o,
  input  logic             q_full_i
);

  typedef struct packed {
    logic flush;
    logic up_is_mid;
    logic bank;
    pix_t pixel;
    logic edge_lo;
    logic col0;
    logic emit_a;
    logic emit_b;
    logic row_end;
  } f1_t;

  function automatic logic [LINE_AW-1:0] last_col(input logic [LW_W-1:0] v);
    logic [LINE_AW-1:0] r;
    if (v == '0) begin
      r = '0;
    end else if (int'(v) > MAX_LINE) begin
      r = LINE_AW'(MAX_LINE - 1);
    end else begin
      r = LINE_AW'(v - 1'b1);
    end
    return r;
  endfunction

  logic [LINE_AW-1:0] last_q, last_d;
  logic [LINE_AW-1:0] col_q, col_d;
  logic [LINE_AW-1:0] fp_q, fp_d;
  logic [1:0]         rows_q, rows_d;
  logic               wb_q, wb_d;
  logic               f1_valid_q, f1_valid_d;
  f1_t                f1_q, f1_d;

  logic               acc, is_flush, flush_ok, keep, mem_we;
  logic [LINE_AW-1:0] c_pix, x, xr, addr_a;
  logic [1:0]         rs_pix;

  // two row banks: bank wb takes the incoming row, the other holds the row above
  pix_t bank0_mem [MAX_LINE];
  pix_t bank1_mem [MAX_LINE];
  pix_t rd0a_q, rd0b_q, rd1a_q, rd1b_q;
  pix_t mid_a, upr_a, mid_b, upr_b;

  assign in_ready_o = !f1_valid_q || !q_full_i;
  assign q_push_o   = f1_valid_q && !q_full_i;
  assign acc        = in_valid_i && in_ready_o;

  always_comb begin
    is_flush = (mf3_cmd_e'(cmd_i) == CMD_FLUSH);
    c_pix    = frame_start_i ? '0 : ((col_q > last_q) ? '0 : col_q);
    rs_pix   = frame_start_i ? 2'd0 : rows_q;
    x        = (fp_q > last_q) ? last_q : fp_q;
    xr       = (x == last_q) ? x : x + 1'b1;
    flush_ok = (rows_q != 2'd0) && (col_q == '0);
    addr_a   = is_flush ? x : c_pix;
    mem_we   = acc && !is_flush;
    keep     = is_flush ? flush_ok : (rs_pix != 2'd0);
  end

  // position state
  always_comb begin
    last_d = last_q;
    col_d  = col_q;
    fp_d   = fp_q;
    rows_d = rows_q;
    wb_d   = wb_q;
    if (cfg_we_i) begin
      last_d = last_col(cfg_wdata_i);
      col_d  = '0;
      fp_d   = '0;
      rows_d = 2'd0;
    end else if (acc) begin
      if (is_flush) begin
        if (flush_ok) begin
          if (x == last_q) begin
            fp_d   = '0;
            rows_d = 2'd0;
          end else begin
            fp_d = x + 1'b1;
          end
        end
      end else begin
        fp_d   = '0;
        rows_d = rs_pix;
        if (c_pix == last_q) begin
          col_d = '0;
          wb_d  = !wb_q;
          if (rs_pix != 2'd2) begin
            rows_d = rs_pix + 2'd1;
          end
        end else begin
          col_d = c_pix + 1'b1;
        end
      end
    end
  end

  always_comb begin
    f1_valid_d = f1_valid_q;
    if (acc) begin
      f1_valid_d = keep;
    end else if (q_push_o) begin
      f1_valid_d = 1'b0;
    end
    f1_d.flush     = is_flush;
    f1_d.up_is_mid = is_flush ? (rows_q == 2'd1) : (rs_pix == 2'd1);
    f1_d.bank      = wb_q;
    f1_d.pixel     = pixel_i;
    f1_d.edge_lo   = is_flush ? (x == '0) : (c_pix == LINE_AW'(1));
    f1_d.col0      = !is_flush && (c_pix == '0);
    f1_d.emit_a    = is_flush || (c_pix != '0);
    f1_d.emit_b    = !is_flush && (c_pix == last_q);
    f1_d.row_end   = is_flush && (x == last_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q     <= last_col(RESET_LW);
      col_q      <= '0;
      fp_q       <= '0;
      rows_q     <= 2'd0;
      wb_q       <= 1'b0;
      f1_valid_q <= 1'b0;
    end else begin
      last_q     <= last_d;
      col_q      <= col_d;
      fp_q       <= fp_d;
      rows_q     <= rows_d;
      wb_q       <= wb_d;
      f1_valid_q <= f1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      f1_q <= f1_d;
    end
  end

  // read-first: the upper pixel comes out of the bank being overwritten
  always_ff @(posedge clk_i) begin
    if (mem_we && !wb_q) begin
      bank0_mem[c_pix] <= pixel_i;
    end
    if (mem_we && wb_q) begin
      bank1_mem[c_pix] <= pixel_i;
    end
    if (acc) begin
      rd0a_q <= bank0_mem[addr_a];
      rd0b_q <= bank0_mem[xr];
      rd1a_q <= bank1_mem[addr_a];
      rd1b_q <= bank1_mem[xr];
    end
  end

  always_comb begin
    mid_a = f1_q.bank ? rd0a_q : rd1a_q;
    upr_a = f1_q.bank ? rd1a_q : rd0a_q;
    mid_b = f1_q.bank ? rd0b_q : rd1b_q;
    upr_b = f1_q.bank ? rd1b_q : rd0b_q;
    q_entry_o.flush     = f1_q.flush;
    q_entry_o.edge_lo   = f1_q.edge_lo;
    q_entry_o.col0      = f1_q.col0;
    q_entry_o.emit_a    = f1_q.emit_a;
    q_entry_o.emit_b    = f1_q.emit_b;
    q_entry_o.row_end   = f1_q.row_end;
    q_entry_o.col_a.up  = f1_q.up_is_mid ? mid_a : upr_a;
    q_entry_o.col_a.mid = mid_a;
    // flushed last row: the row below clamps to itself
    q_entry_o.col_a.low = f1_q.flush ? mid_a : f1_q.pixel;
    q_entry_o.col_b.up  = f1_q.up_is_mid ? mid_b : upr_b;
    q_entry_o.col_b.mid = mid_b;
    q_entry_o.col_b.low = mid_b;
  end

endmodule

FILE: hw/rtl/mf3_fifo.sv
// short work item queue between front and back
module mf3_fifo import mf3_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  mf3_entry_t entry_i,
  output logic       full_o,
  input  logic       pop_i,
  output mf3_entry_t head_o,
  output logic       head_valid_o
);

  localparam int CW = QAW + 1;

  mf3_entry_t     slot_q [QDEPTH];
  logic [QAW-1:0] wp_q, rp_q;
  logic [CW-1:0]  cnt_q;

  assign full_o       = (cnt_q == CW'(QDEPTH));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = slot_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wp_q <= wp_q + 1'b1;
      end
      if (pop_i) begin
        rp_q <= rp_q + 1'b1;
      end
      cnt_q <= cnt_q + CW'(push_i) - CW'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wp_q] <= entry_i;
    end
  end

endmodule

FILE: hw/rtl/mf3_back.sv
// back end: 3x3 window, result sequencing and pipelined median network
module mf3_back import mf3_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  mf3_entry_t head_i,
  input  logic       head_valid_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output pix_t       median_value_o,
  output logic       row_end_o,
  output logic       last_of_run_o
);

  typedef struct packed {
    pix_t lo;
    pix_t mi;
    pix_t hi;
  } trio_t;

  typedef struct packed {
    logic row_end;
    logic last;
  } tag_t;

  function automatic trio_t sort3(input pix_t a, input pix_t b, input pix_t c);
    pix_t  lo1, hi1;
    trio_t r;
    lo1 = (a < b) ? a : b;
    hi1 = (a < b) ? b : a;
    if (c < lo1) begin
      r = '{lo: c, mi: lo1, hi: hi1};
    end else if (c < hi1) begin
      r = '{lo: lo1, mi: c, hi: hi1};
    end else begin
      r = '{lo: lo1, mi: hi1, hi: c};
    end
    return r;
  endfunction

  function automatic pix_t max3(input pix_t a, input pix_t b, input pix_t c);
    pix_t m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  function automatic pix_t min3(input pix_t a, input pix_t b, input pix_t c);
    pix_t m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  function automatic pix_t med3(input pix_t a, input pix_t b, input pix_t c);
    pix_t lo, hi, t;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    t  = (hi < c) ? hi : c;
    return (lo > t) ? lo : t;
  endfunction

  logic     adv, go, two, sel_b, iss;
  logic     phase_q, phase_d;
  mf3_col_t win_c_q, win_r_q;
  mf3_col_t n0, n1, n2, t0, t1, t2;
  tag_t     tag;

  logic     s1_v_q, s2_v_q, s3_v_q, ov_q;
  mf3_col_t s1_c_q [3];
  tag_t     s1_tag_q, s2_tag_q, s3_tag_q;
  trio_t    s2_t_q [3];
  pix_t     s3_lo_q, s3_mi_q, s3_hi_q;
  pix_t     med_q;
  tag_t     out_tag_q;

  // whole median pipe moves together, held while the result waits
  assign adv = !ov_q || out_ready_i;

  always_comb begin
    two     = head_i.emit_a && head_i.emit_b;
    sel_b   = phase_q || !head_i.emit_a;
    go      = head_valid_i && adv;
    iss     = go && (head_i.emit_a || head_i.emit_b);
    pop_o   = go && !(two && !phase_q);
    phase_d = phase_q;
    if (go) begin
      phase_d = two && !phase_q;
    end

    if (head_i.flush) begin
      // left column carries over from the previous flush unless at column zero
      n0 = head_i.edge_lo ? head_i.col_a : win_c_q;
      n1 = head_i.col_a;
      n2 = head_i.col_b;
    end else begin
      n0 = win_c_q;
      n1 = win_r_q;
      n2 = head_i.col_a;
    end

    t0 = n0;
    t1 = n1;
    t2 = n2;
    if (!head_i.flush) begin
      if (!sel_b) begin
        if (head_i.edge_lo) begin
          t0 = n1;
        end
      end else begin
        // row end: right clamps to the last column
        t0 = head_i.col0 ? n2 : n1;
        t1 = n2;
      end
    end

    tag.row_end = head_i.flush ? head_i.row_end : sel_b;
    tag.last    = head_i.flush || sel_b || !head_i.emit_b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 1'b0;
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      phase_q <= phase_d;
      if (adv) begin
        s1_v_q <= iss;
        s2_v_q <= s1_v_q;
        s3_v_q <= s2_v_q;
        ov_q   <= s3_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      win_c_q <= n1;
      win_r_q <= n2;
    end
    if (adv) begin
      s1_c_q[0] <= t0;
      s1_c_q[1] <= t1;
      s1_c_q[2] <= t2;
      s1_tag_q  <= tag;
      for (int i = 0; i < 3; i++) begin
        s2_t_q[i] <= sort3(s1_c_q[i].up, s1_c_q[i].mid, s1_c_q[i].low);
      end
      s2_tag_q  <= s1_tag_q;
      s3_lo_q   <= max3(s2_t_q[0].lo, s2_t_q[1].lo, s2_t_q[2].lo);
      s3_mi_q   <= med3(s2_t_q[0].mi, s2_t_q[1].mi, s2_t_q[2].mi);
      s3_hi_q   <= min3(s2_t_q[0].hi, s2_t_q[1].hi, s2_t_q[2].hi);
      s3_tag_q  <= s2_tag_q;
      med_q     <= med3(s3_lo_q, s3_mi_q, s3_hi_q);
      out_tag_q <= s3_tag_q;
    end
  end

  assign out_valid_o    = ov_q;
  assign median_value_o = med_q;
  assign row_end_o      = out_tag_q.row_end;
  assign last_of_run_o  = out_tag_q.last;

endmodule

FILE: hw/rtl/median_filter_3x3_replicate.sv
// top level of the 3x3 median filter with replicated image edges
//
//  channel   direction  handshake               payload
//  cfg       in         cfg_we_i                cfg_wdata_i (line width)
//  in        in         in_valid_i/in_ready_o   cmd_i, pixel_i, frame_start_i
//  out       out        out_valid_o/out_ready_i median_value_o, row_end_o, last_of_run_o
//
// one item per cycle while the queue has room; the last-column item of a row can issue
// two results to the back in turn, so a long unbroken stream stalls the input once
// per row once the 4-entry queue fills. the second result of an item follows the first.
// reset clears position state and sets the line width to 512; row stores are not
// cleared and need no clearing pass. a stall on out freezes the median pipe only;
// the front keeps running until the queue fills.
module median_filter_3x3_replicate import mf3_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [LW_W-1:0] cfg_wdata_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic            cmd_i,
  input  logic [7:0]      pixel_i,
  input  logic            frame_start_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [7:0]      median_value_o,
  output logic            row_end_o,
  output logic            last_of_run_o
);

  mf3_entry_t q_entry, q_head;
  logic       q_push, q_full, q_pop, q_head_valid;

  mf3_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .cmd_i         (cmd_i),
    .pixel_i       (pixel_i),
    .frame_start_i (frame_start_i),
    .q_entry_o     (q_entry),
    .q_push_o      (q_push),
    .q_full_i      (q_full)
  );

  mf3_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (q_push),
    .entry_i      (q_entry),
    .full_o       (q_full),
    .pop_i        (q_pop),
    .head_o       (q_head),
    .head_valid_o (q_head_valid)
  );

  mf3_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_i         (q_head),
    .head_valid_i   (q_head_valid),
    .pop_o          (q_pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .median_value_o (median_value_o),
    .row_end_o      (row_end_o),
    .last_of_run_o  (last_of_run_o)
  );

  // back only retires a queue entry that is there
  a_pop_has_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_head_valid)
    else $error("queue popped while empty");

  // a row end result always closes its run
  a_row_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && row_end_o) |-> last_of_run_o)
    else $error("row end result not marked last of run");

  // input only stalls when the queue is backed up
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> q_full)
    else $error("input stalled with room in the queue");

endmodule

FILE: bench/tb_top.sv
// testbench for the 3x3 replicate median filter: directed table, random frames, self-checking
`timescale 1ns / 100ps

module tb_top import mf3_pkg::*; ();

  localparam int SETTLE    = 24;    // generous against the item-to-result latency
  localparam int LONG_HOLD = 400;
  localparam int WATCHDOG  = 3000;
  localparam logic [LW_W-1:0] WIDTH_ALL_ONES = '1;

  typedef struct packed {
    pix_t med;
    logic row_end;
    logic last;
  } median_res_t;

  typedef struct {
    bit              is_cfg;
    logic [LW_W-1:0] cfg_val;
    mf3_cmd_e        cmd;
    pix_t            px;
    logic            fs;
    bit              typed;
    int              n;
    median_res_t     res;
  } stim_row_t;

  logic            clk_i         = 1'b0;
  logic            rst_ni        = 1'b0;
  logic            cfg_we_i      = 1'b0;
  logic [LW_W-1:0] cfg_wdata_i   = '0;
  logic            in_valid_i    = 1'b0;
  logic            in_ready_o;
  logic            cmd_i         = 1'b0;
  logic [7:0]      pixel_i       = '0;
  logic            frame_start_i = 1'b0;
  logic            out_valid_o;
  logic            out_ready_i   = 1'b0;
  logic [7:0]      median_value_o;
  logic            row_end_o;
  logic            last_of_run_o;

  median_filter_3x3_replicate i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .cmd_i          (cmd_i),
    .pixel_i        (pixel_i),
    .frame_start_i  (frame_start_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .median_value_o (median_value_o),
    .row_end_o      (row_end_o),
    .last_of_run_o  (last_of_run_o)
  );

  always #2 clk_i = ~clk_i;

  // predictor state
  logic [LW_W-1:0] lw = RESET_LW;
  pix_t        up_row  [MAX_LINE];
  pix_t        mid_row [MAX_LINE];
  pix_t        win     [9] = '{default: '0};
  int unsigned col_pos   = 0;
  int unsigned rows_seen = 0;
  int unsigned flush_pos = 0;

  median_res_t median_q [$];
  stim_row_t   plan [$];

  int n_items    = 0;
  int n_expected = 0;
  int n_results  = 0;
  int n_mismatch = 0;
  int n_cfg      = 0;
  int max_w      = 0;
  int tx_mode    = 0;
  int rx_mode    = 1;
  int hold_req   = 0;
  int hold_ack   = 0;
  int rx_wait    = 0;
  int quiet      = 0;

  function automatic int unsigned eff_width();
    if (lw == 0) return 1;
    if (lw > MAX_LINE) return MAX_LINE;
    return 32'(lw);
  endfunction

  // fifth smallest: the value with at most four below it and at least five at or below
  function automatic pix_t median9(input pix_t v [9]);
    int lt, le;
    for (int i = 0; i < 9; i++) begin
      lt = 0;
      le = 0;
      for (int j = 0; j < 9; j++) begin
        if (v[j] < v[i]) lt++;
        if (v[j] <= v[i]) le++;
      end
      if (lt <= 4 && le >= 5) return v[i];
    end
    return '0;
  endfunction

  function automatic pix_t win_median(input int l, input int c, input int r);
    pix_t v [9];
    for (int row = 0; row < 3; row++) begin
      v[row*3]   = win[row*3 + l];
      v[row*3+1] = win[row*3 + c];
      v[row*3+2] = win[row*3 + r];
    end
    return median9(v);
  endfunction

  // advances the predictor by one accepted item, returns the number of results
  function automatic int filter_step(input mf3_cmd_e cmd, input pix_t px, input logic fs,
                                     output median_res_t res [2], output bit ignored);
    int unsigned w, c, x;
    int unsigned cols [3];
    pix_t v [9];
    pix_t mid, upv;
    int n;
    w = eff_width();
    n = 0;
    ignored = 1'b0;
    res[0] = '0;
    res[1] = '0;
    if (cmd == CMD_FLUSH) begin
      if (rows_seen == 0 || col_pos != 0) begin
        ignored = 1'b1;
        return 0;
      end
      x = (flush_pos >= w) ? w - 1 : flush_pos;
      cols[0] = (x == 0) ? 0 : x - 1;
      cols[1] = x;
      cols[2] = (x + 1 >= w) ? w - 1 : x + 1;
      for (int k = 0; k < 3; k++) begin
        v[k]   = (rows_seen == 1) ? mid_row[cols[k]] : up_row[cols[k]];
        v[3+k] = mid_row[cols[k]];
        v[6+k] = mid_row[cols[k]];  // bottom edge replicates the last row
      end
      res[0].med     = median9(v);
      res[0].row_end = (x == w - 1);
      res[0].last    = 1'b1;
      if (x == w - 1) begin
        flush_pos = 0;
        rows_seen = 0;
      end else begin
        flush_pos = x + 1;
      end
      return 1;
    end
    if (fs) begin
      col_pos   = 0;
      rows_seen = 0;
    end
    flush_pos = 0;
    c = (col_pos >= w) ? 0 : col_pos;
    if (rows_seen == 0) begin
      mid_row[c] = px;
    end else begin
      mid = mid_row[c];
      upv = (rows_seen == 1) ? mid : up_row[c];
      for (int row = 0; row < 3; row++) begin
        win[row*3]   = win[row*3+1];
        win[row*3+1] = win[row*3+2];
      end
      win[2] = upv;
      win[5] = mid;
      win[8] = px;
      up_row[c]  = mid;
      mid_row[c] = px;
      if (c >= 1) begin
        res[n].med     = win_median((c == 1) ? 1 : 0, 1, 2);
        res[n].row_end = 1'b0;
        res[n].last    = (c != w - 1);
        n++;
      end
      if (c == w - 1) begin
        res[n].med     = win_median((c == 0) ? 2 : 1, 2, 2);
        res[n].row_end = 1'b1;
        res[n].last    = 1'b1;
        n++;
      end
    end
    if (c == w - 1) begin
      col_pos = 0;
      if (rows_seen < 2) rows_seen++;
    end else begin
      col_pos = c + 1;
    end
    return n;
  endfunction

  function automatic int pick_gap(input int mode);
    int r;
    r = $urandom_range(99);
    if (mode == 0) return 0;
    if (r < ((mode == 1) ? 75 : 40)) return 0;
    if (r < 97) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic pix_t rand_pixel();
    int r;
    r = $urandom_range(9);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return pix_t'($urandom);
  endfunction

  function automatic stim_row_t mk_item(input mf3_cmd_e cmd, input pix_t px, input logic fs,
                                        input bit typed, input int n, input pix_t med);
    stim_row_t s;
    s.is_cfg      = 1'b0;
    s.cfg_val     = '0;
    s.cmd         = cmd;
    s.px          = px;
    s.fs          = fs;
    s.typed       = typed;
    s.n           = n;
    s.res.med     = med;
    s.res.row_end = 1'b1;
    s.res.last    = 1'b1;
    return s;
  endfunction

  function automatic stim_row_t mk_cfg(input logic [LW_W-1:0] val);
    stim_row_t s;
    s = mk_item(CMD_PIXEL, '0, 1'b0, 1'b0, 0, '0);
    s.is_cfg  = 1'b1;
    s.cfg_val = val;
    return s;
  endfunction

  task automatic send_item(input mf3_cmd_e cmd, input pix_t px, input logic fs,
                           input bit typed, input int t_n, input median_res_t t_res);
    median_res_t res [2];
    bit ignored;
    int n, gap;
    cmd_i         <= cmd;
    pixel_i       <= px;
    frame_start_i <= fs;
    in_valid_i    <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    n = filter_step(cmd, px, fs, res, ignored);
    if (typed) begin
      if (t_n == 1) median_q.push_back(t_res);
      n_expected += t_n;
    end else begin
      for (int i = 0; i < n; i++) median_q.push_back(res[i]);
      n_expected += n;
    end
    if (!ignored) n_items++;
    gap = pick_gap(tx_mode);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // pixels that make no result may still be in the pipe, hence the settle time
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (median_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_width(input logic [LW_W-1:0] val);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i  <= 1'b0;
    lw        = val;
    col_pos   = 0;
    rows_seen = 0;
    flush_pos = 0;
    n_cfg++;
    if (int'(eff_width()) > max_w) max_w = int'(eff_width());
  endtask

  function automatic logic [LW_W-1:0] pick_width();
    int r;
    r = $urandom_range(99);
    if (r < 10) return LW_W'(1);
    if (r < 20) return LW_W'(2);
    if (r < 24) return LW_W'(0);
    if (r < 30) return LW_W'($urandom_range(41, 120));
    return LW_W'($urandom_range(3, 40));
  endfunction

  // mostly well-formed frames with random content, plus stray flushes and restarts
  task automatic run_phase(input logic [LW_W-1:0] val);
    int unsigned w;
    int frames, rows, nfl, sel;
    logic fs;
    write_width(val);
    w       = eff_width();
    tx_mode = $urandom_range(2);
    rx_mode = $urandom_range(2);
    frames  = $urandom_range(1, 3);
    for (int f = 0; f < frames; f++) begin
      rows = $urandom_range(1, (w < 4) ? 8 : 4);
      for (int r = 0; r < rows; r++) begin
        for (int c = 0; c < w; c++) begin
          if ($urandom_range(99) < 3)
            send_item(CMD_FLUSH, rand_pixel(), 1'($urandom), 1'b0, 0, '0);
          fs = (r == 0 && c == 0 && $urandom_range(3) != 0) || ($urandom_range(199) == 0);
          send_item(CMD_PIXEL, rand_pixel(), fs, 1'b0, 0, '0);
        end
      end
      sel = $urandom_range(9);
      if (sel < 7) nfl = w + (($urandom_range(3) == 0) ? 1 : 0);
      else if (sel < 9) nfl = $urandom_range(1, w);
      else nfl = 0;
      for (int k = 0; k < nfl; k++)
        send_item(CMD_FLUSH, rand_pixel(), 1'($urandom), 1'b0, 0, '0);
    end
  endtask

  // receiver: random stalls, plus the long hold-off on request
  always @(posedge clk_i) begin : drive_ready
    int len;
    if (hold_req != hold_ack) begin
      hold_ack = hold_req;
      rx_wait  = LONG_HOLD;
    end
    if (rx_wait > 0) begin
      rx_wait--;
      out_ready_i <= 1'b0;
    end else begin
      len = pick_gap(rx_mode);
      if (len > 0) begin
        rx_wait = len - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : check_out
    median_res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      n_results++;
      if (median_q.size() == 0) begin
        if (n_mismatch < 10)
          $display("unexpected result %0d: median %0d row_end %0b last %0b",
                   n_results, median_value_o, row_end_o, last_of_run_o);
        n_mismatch++;
      end else begin
        want = median_q.pop_front();
        if (want.med !== median_value_o || want.row_end !== row_end_o ||
            want.last !== last_of_run_o) begin
          if (n_mismatch < 10)
            $display("mismatch at result %0d: want %0d/%0b/%0b got %0d/%0b/%0b", n_results,
                     want.med, want.row_end, want.last,
                     median_value_o, row_end_o, last_of_run_o);
          n_mismatch++;
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i) quiet = 0;
    else quiet++;
    if (quiet >= WATCHDOG) begin
      $display("no transfer for %0d cycles, %0d results outstanding", quiet, median_q.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    int target;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // at reset width: flush with no row is dropped, first pixel only stored
    plan.push_back(mk_item(CMD_FLUSH, 8'h00, 1'b0, 1'b1, 0, 8'h00));
    plan.push_back(mk_item(CMD_PIXEL, 8'h5A, 1'b1, 1'b1, 0, 8'h00));
    // width 0 acts as 1: each result is the median of one replicated column
    plan.push_back(mk_cfg(LW_W'(0)));
    plan.push_back(mk_item(CMD_PIXEL, 8'h00, 1'b1, 1'b1, 0, 8'h00));
    plan.push_back(mk_item(CMD_PIXEL, 8'hFF, 1'b0, 1'b1, 1, 8'h00));
    plan.push_back(mk_item(CMD_PIXEL, 8'hFF, 1'b0, 1'b1, 1, 8'hFF));
    plan.push_back(mk_item(CMD_FLUSH, 8'h00, 1'b0, 1'b1, 1, 8'hFF));
    plan.push_back(mk_item(CMD_FLUSH, 8'h00, 1'b0, 1'b1, 0, 8'h00));  // already drained
    plan.push_back(mk_item(CMD_PIXEL, 8'h80, 1'b0, 1'b1, 0, 8'h00));
    plan.push_back(mk_item(CMD_PIXEL, 8'h01, 1'b1, 1'b1, 0, 8'h00));  // restart frame
    plan.push_back(mk_item(CMD_PIXEL, 8'h7F, 1'b0, 1'b1, 1, 8'h01));
    plan.push_back(mk_cfg(LW_W'(3)));
    plan.push_back(mk_item(CMD_PIXEL, 8'h10, 1'b1, 1'b0, 0, 8'h00));
    plan.push_back(mk_item(CMD_PIXEL, 8'hF0, 1'b0, 1'b0, 0, 8'h00));
    plan.push_back(mk_item(CMD_PIXEL, 8'h33, 1'b0, 1'b0, 0, 8'h00));
    plan.push_back(mk_item(CMD_PIXEL, 8'h0C, 1'b0, 1'b0, 0, 8'h00));
    plan.push_back(mk_item(CMD_FLUSH, 8'h00, 1'b0, 1'b0, 0, 8'h00));  // mid-row, dropped
    plan.push_back(mk_item(CMD_PIXEL, 8'hE7, 1'b0, 1'b0, 0, 8'h00));
    plan.push_back(mk_item(CMD_PIXEL, 8'h5A, 1'b0, 1'b0, 0, 8'h00));
    plan.push_back(mk_item(CMD_FLUSH, 8'hAA, 1'b1, 1'b0, 0, 8'h00));  // partial flush
    plan.push_back(mk_item(CMD_PIXEL, 8'h99, 1'b0, 1'b0, 0, 8'h00));  // continues the frame
    plan.push_back(mk_item(CMD_PIXEL, 8'h00, 1'b0, 1'b0, 0, 8'h00));
    plan.push_back(mk_item(CMD_PIXEL, 8'hFF, 1'b0, 1'b0, 0, 8'h00));
    for (int k = 0; k < 4; k++)
      plan.push_back(mk_item(CMD_FLUSH, 8'h00, 1'b0, 1'b0, 0, 8'h00));

    foreach (plan[i]) begin
      if (plan[i].is_cfg) write_width(plan[i].cfg_val);
      else send_item(plan[i].cmd, plan[i].px, plan[i].fs, plan[i].typed, plan[i].n,
                     plan[i].res);
    end

    while (n_items < 200) run_phase(pick_width());

    // widest row: two full rows and a short flush, with a long output hold-off
    write_width(WIDTH_ALL_ONES);
    tx_mode = 0;
    rx_mode = 0;
    for (int r = 0; r < 2; r++) begin
      for (int c = 0; c < eff_width(); c++) begin
        if (r == 1 && c == 100) hold_req++;
        send_item(CMD_PIXEL, rand_pixel(), (r == 0 && c == 0), 1'b0, 0, '0);
      end
    end
    repeat ($urandom_range(1, 8)) send_item(CMD_FLUSH, rand_pixel(), 1'b0, 1'b0, 0, '0);

    target = n_items + 200;
    while (n_items < target) run_phase(pick_width());
    wait_idle();

    $display("%0d items over %0d width settings (widest %0d), %0d of %0d results checked",
             n_items, n_cfg, max_w, n_results, n_expected);
    $display("%0d mismatches, %0d long output hold-off", n_mismatch, hold_req);
    if (n_mismatch == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
